### rtl/itaf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character constants for the integer-to-ASCII formatter.
// No dependencies; every rtl file imports this package.
package itaf_pkg;

    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned MAX_WIDTH_DEF = 63;
    localparam int unsigned VALUE_BITS    = 32;
    localparam int unsigned CNT_BITS      = 6;

    typedef enum logic [1:0] {
        OP_OCT  = 2'd0,
        OP_UDEC = 2'd1,
        OP_SDEC = 2'd2,
        OP_HEX  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        SG_NONE,
        SG_MINUS,
        SG_PLUS,
        SG_SPACE
    } t_sign;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } t_state;

    localparam logic [6:0] CH_SPACE   = 7'h20;
    localparam logic [6:0] CH_PLUS    = 7'h2b;
    localparam logic [6:0] CH_MINUS   = 7'h2d;
    localparam logic [6:0] CH_ZERO    = 7'h30;
    localparam logic [6:0] CH_LOWER_A = 7'h61;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        t_opcode               opcode;
        logic [CNT_BITS-1:0]   pad_width;
        logic                  zero_pad;
        logic                  left_justify;
        logic                  force_plus;
        logic                  space_sign;
        logic                  half_word;
    } t_in_item;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last;
    } t_out_item;

    // Control from the sequencer to the digit unit.
    typedef struct packed {
        logic    load;
        logic    shift;
        t_opcode mode;
    } t_dig_ctrl;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] dx;
        dx = {3'b000, d};
        if (d < 4'd10) begin
            digit_char = CH_ZERO + dx;
        end else begin
            digit_char = CH_LOWER_A + dx - 7'd10;
        end
    endfunction

    function automatic logic [6:0] sign_char(input t_sign s);
        unique case (s)
            SG_MINUS: sign_char = CH_MINUS;
            SG_PLUS:  sign_char = CH_PLUS;
            SG_SPACE: sign_char = CH_SPACE;
            SG_NONE:  sign_char = CH_SPACE;
        endcase
    endfunction

endpackage

### rtl/itaf_digit_unit.sv
`timescale 1ns / 1ps
// Digit register of the formatter: loads octal/hex digits directly and runs the
// shared shift-and-add-3 step for decimal, one bit per cycle. Depends on itaf_pkg.
module itaf_digit_unit #(
    parameter int unsigned WORD_BITS = itaf_pkg::WORD_BITS_DEF,
    localparam int unsigned NDIG     = (WORD_BITS + 2) / 3,
    localparam int unsigned IDX_BITS = $clog2(NDIG)
) (
    input  logic                  i_clk,
    input  itaf_pkg::t_dig_ctrl   i_ctrl,
    input  logic [WORD_BITS-1:0]  i_mag,
    input  logic [IDX_BITS-1:0]   i_idx,
    output logic [3:0]            o_digit
);
    import itaf_pkg::*;

    localparam int unsigned XBITS = 4 * NDIG;

    logic [NDIG-1:0][3:0]         r_dig, n_dig, w_adj;
    logic [WORD_BITS-1:0]         r_bin, n_bin;
    logic [XBITS+WORD_BITS-1:0]   w_wide;
    logic [XBITS-1:0]             w_ext;
    logic [XBITS:0]               w_sh;

    always_comb begin
        w_wide = {{XBITS{1'b0}}, i_mag};
        w_ext  = w_wide[XBITS-1:0];
        for (int i = 0; i < NDIG; i++) begin
            w_adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
        w_sh  = {w_adj, r_bin[WORD_BITS-1]};
        n_dig = r_dig;
        n_bin = r_bin;
        if (i_ctrl.load) begin
            unique case (i_ctrl.mode)
                OP_OCT: begin
                    for (int i = 0; i < NDIG; i++) begin
                        n_dig[i] = {1'b0, w_ext[3*i +: 3]};
                    end
                end
                OP_HEX: begin
                    n_dig = w_ext;
                end
                OP_UDEC, OP_SDEC: begin
                    n_dig = '0;
                    n_bin = i_mag;
                end
            endcase
        end else if (i_ctrl.shift) begin
            // adjust every BCD digit, then shift in the next binary bit
            n_dig = w_sh[XBITS-1:0];
            n_bin = {r_bin[WORD_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig <= n_dig;
        r_bin <= n_bin;
    end

    assign o_digit = r_dig[i_idx];

endmodule

### rtl/integer_to_ascii_formatter_core.sv
`timescale 1ns / 1ps
// Top level of the integer-to-ASCII formatter: sign handling, sequencer, output register.
// Depends on itaf_pkg and itaf_digit_unit.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | to core   | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//  out     | from core | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// Sequence: an item is accepted, runs through the shift-and-add-3 unit for decimal
//   (not for octal/hex), then a leading-zero scan, then one character per cycle
//   while not stalled, max(width, len + sign) characters in all.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// Stalls: o_in_stall is high from accept until the last character is loaded
//   into the output register; that register holds while it is valid and i_out_stall is high.
module integer_to_ascii_formatter_core #(
    parameter int unsigned WORD_BITS = itaf_pkg::WORD_BITS_DEF,
    parameter int unsigned MAX_WIDTH = itaf_pkg::MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  itaf_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output itaf_pkg::t_out_item o_out_data
);
    import itaf_pkg::*;

    localparam int unsigned NDIG     = (WORD_BITS + 2) / 3;
    localparam int unsigned IDX_BITS = $clog2(NDIG);
    localparam int unsigned CNT_W    = $clog2(WORD_BITS);

    // ---------------- accept-side decode ----------------
    logic                            w_accept;
    logic [WORD_BITS+VALUE_BITS-1:0] w_vwide;
    logic [WORD_BITS-1:0]            w_v, w_vneg, w_mag;
    logic [15:0]                     w_h, w_hneg, w_hsel;
    logic [WORD_BITS+15:0]           w_hwide;
    logic                            w_isneg;
    t_sign                           w_sign;
    logic [CNT_BITS-1:0]             w_width;

    // ---------------- sequencer registers ----------------
    t_state               r_state, n_state;
    t_sign                r_sign, n_sign;
    logic                 r_left, n_left;
    logic                 r_zero, n_zero;
    logic [CNT_BITS-1:0]  r_width, n_width;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [IDX_BITS-1:0]  r_idx, n_idx;
    logic [CNT_BITS-1:0]  r_pos, n_pos;
    logic [CNT_BITS-1:0]  r_last_pos, n_last_pos;
    logic [CNT_BITS-1:0]  r_pad, n_pad;
    logic [CNT_BITS-1:0]  r_total, n_total;
    logic [CNT_BITS-1:0]  r_anchor, n_anchor;
    logic                 r_ovalid, n_ovalid;
    t_out_item            r_odata, n_odata;

    // ---------------- emit-side helpers ----------------
    t_dig_ctrl            w_ctrl;
    logic [IDX_BITS-1:0]  w_read_idx;
    logic [3:0]           w_digit;
    logic                 w_has_sign;
    logic [CNT_BITS-1:0]  w_sbit;
    logic [CNT_BITS-1:0]  w_len, w_tot, w_di;
    logic [6:0]           w_char;
    logic                 w_out_load;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Narrow the argument, take the magnitude and pick the sign character.
    always_comb begin
        w_vwide = {{WORD_BITS{1'b0}}, i_in_data.value};
        w_v     = w_vwide[WORD_BITS-1:0];
        w_vneg  = '0 - w_v;
        w_h     = w_v[15:0];
        w_hneg  = 16'd0 - w_h;
        w_isneg = 1'b0;
        w_hsel  = w_h;
        if (i_in_data.opcode == OP_SDEC && i_in_data.half_word && w_h[15]) begin
            w_hsel = w_hneg;
        end
        w_hwide = {{WORD_BITS{1'b0}}, w_hsel};
        w_mag   = w_v;
        if (i_in_data.opcode == OP_SDEC) begin
            if (i_in_data.half_word) begin
                w_isneg = w_h[15];
                w_mag   = w_hwide[WORD_BITS-1:0];
            end else begin
                w_isneg = w_v[WORD_BITS-1];
                w_mag   = w_isneg ? w_vneg : w_v;
            end
        end else if (i_in_data.half_word) begin
            w_mag = w_hwide[WORD_BITS-1:0];
        end

        w_sign = SG_NONE;
        if (i_in_data.opcode == OP_SDEC) begin
            priority if (w_isneg) begin
                w_sign = SG_MINUS;
            end else if (i_in_data.force_plus) begin
                w_sign = SG_PLUS;
            end else if (i_in_data.space_sign) begin
                w_sign = SG_SPACE;
            end else begin
                w_sign = SG_NONE;
            end
        end

        // saturate the field width
        w_width = (i_in_data.pad_width > CNT_BITS'(MAX_WIDTH)) ?
                  CNT_BITS'(MAX_WIDTH) : i_in_data.pad_width;
    end

    // Digit register and the shared shift-and-add-3 unit.
    itaf_digit_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_digit (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_mag   (w_mag),
        .i_idx   (w_read_idx),
        .o_digit (w_digit)
    );

    // Character for the current output position.
    always_comb begin
        w_has_sign = (r_sign != SG_NONE);
        w_sbit     = {{(CNT_BITS-1){1'b0}}, w_has_sign};
        w_di       = r_anchor - r_pos;
        w_read_idx = (r_state == ST_EMIT) ? w_di[IDX_BITS-1:0] : r_idx;
        w_len      = CNT_BITS'(r_idx) + CNT_BITS'(1);
        w_tot      = w_len + w_sbit;

        if (r_left) begin
            priority if (w_has_sign && r_pos == '0) begin
                w_char = sign_char(r_sign);
            end else if (r_pos < r_total) begin
                w_char = digit_char(w_digit);
            end else begin
                w_char = CH_SPACE;
            end
        end else if (r_zero) begin
            priority if (w_has_sign && r_pos == '0) begin
                w_char = sign_char(r_sign);
            end else if (r_pos < r_pad + w_sbit) begin
                w_char = CH_ZERO;
            end else begin
                w_char = digit_char(w_digit);
            end
        end else begin
            priority if (r_pos < r_pad) begin
                w_char = CH_SPACE;
            end else if (w_has_sign && r_pos == r_pad) begin
                w_char = sign_char(r_sign);
            end else begin
                w_char = digit_char(w_digit);
            end
        end
    end

    assign w_out_load = (r_state == ST_EMIT) && (!r_ovalid || !i_out_stall);

    // Next state and datapath control.
    always_comb begin
        n_state    = r_state;
        n_sign     = r_sign;
        n_left     = r_left;
        n_zero     = r_zero;
        n_width    = r_width;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_last_pos = r_last_pos;
        n_pad      = r_pad;
        n_total    = r_total;
        n_anchor   = r_anchor;
        n_odata    = r_odata;
        n_ovalid   = r_ovalid && i_out_stall;
        w_ctrl      = '0;
        w_ctrl.mode = i_in_data.opcode;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctrl.load = 1'b1;
                    n_sign  = w_sign;
                    n_left  = i_in_data.left_justify;
                    n_zero  = i_in_data.zero_pad;
                    n_width = w_width;
                    if (i_in_data.opcode == OP_UDEC || i_in_data.opcode == OP_SDEC) begin
                        n_cnt   = CNT_W'(WORD_BITS - 1);
                        n_state = ST_CONV;
                    end else begin
                        n_idx   = IDX_BITS'(NDIG - 1);
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_CONV: begin
                // one binary bit per cycle into the BCD digits
                w_ctrl.shift = 1'b1;
                if (r_cnt == '0) begin
                    n_idx   = IDX_BITS'(NDIG - 1);
                    n_state = ST_SCAN;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_SCAN: begin
                // drop leading zeros, keep at least one digit
                if (w_digit == 4'd0 && r_idx != '0) begin
                    n_idx = r_idx - IDX_BITS'(1);
                end else begin
                    n_total = w_tot;
                    n_pos   = '0;
                    if (r_width > w_tot) begin
                        n_pad      = r_width - w_tot;
                        n_last_pos = r_width - CNT_BITS'(1);
                    end else begin
                        n_pad      = '0;
                        n_last_pos = w_tot - CNT_BITS'(1);
                    end
                    n_anchor = r_left ? (w_tot - CNT_BITS'(1)) : n_last_pos;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_load) begin
                    n_ovalid          = 1'b1;
                    n_odata.char_code = w_char;
                    n_odata.last      = (r_pos == r_last_pos);
                    n_pos             = r_pos + CNT_BITS'(1);
                    if (r_pos == r_last_pos) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sign     <= n_sign;
        r_left     <= n_left;
        r_zero     <= n_zero;
        r_width    <= n_width;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_last_pos <= n_last_pos;
        r_pad      <= n_pad;
        r_total    <= n_total;
        r_anchor   <= n_anchor;
        r_odata    <= n_odata;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    // An accepted item blocks the input channel in the following cycle.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after transfer");

    // The position counter never runs past the last character.
    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_pos <= r_last_pos))
        else $error("emit position beyond last character");

    // Loading the last character returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_pos == r_last_pos) |=> (r_state == ST_IDLE && r_odata.last))
        else $error("last character did not end the conversion");

    // The field always holds the whole text.
    a_field_fits_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |->
            ({1'b0, r_last_pos} + 7'd1 >= {1'b0, r_total}))
        else $error("field shorter than sign and digits");

endmodule
